// File: hw/rtl/prsl_pkg.sv
// types and codes shared by the paired register switch list
package prsl_pkg;

	localparam int unsigned NumW = 32;
	localparam int unsigned ValW = 64;
	localparam int unsigned CntW = 4;

	localparam logic ActAdd    = 1'b0;
	localparam logic ActRemove = 1'b1;

	localparam logic StsDone   = 1'b0;
	localparam logic StsNoRoom = 1'b1;

	typedef struct packed {
		logic            action;
		logic [NumW-1:0] reg_number;
		logic [ValW-1:0] guest_value;
		logic [ValW-1:0] host_value;
		logic            guest_only;
	} prsl_in_t;

	typedef struct packed {
		logic            status;
		logic            guest_hit;
		logic            host_hit;
		logic [CntW-1:0] guest_count;
		logic [CntW-1:0] host_count;
	} prsl_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DECIDE,
		ST_MOVE,
		ST_FINISH
	} prsl_state_t;

	typedef struct packed {
		logic load;
		logic search_rd;
		logic search_cmp;
		logic last_rd;
		logic commit_add;
		logic commit_move;
		logic result;
	} prsl_cmd_t;

	typedef struct packed {
		logic search_last;
		logic remove;
		logic out_busy;
	} prsl_sts_t;

endpackage

// File: hw/rtl/prsl_ctrl.sv
// sequencing state machine for the switch list
module prsl_ctrl
	import prsl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  prsl_sts_t sts,
	output prsl_cmd_t cmd
);

	prsl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.search_rd = 1'b1;
				state_d       = ST_CMP;
			end
			ST_CMP: begin
				cmd.search_cmp = 1'b1;
				state_d        = sts.search_last ? ST_DECIDE : ST_READ;
			end
			ST_DECIDE: begin
				if (sts.remove) begin
					cmd.last_rd = 1'b1;
					state_d     = ST_MOVE;
				end else begin
					cmd.commit_add = 1'b1;
					state_d        = ST_FINISH;
				end
			end
			ST_MOVE: begin
				cmd.commit_move = 1'b1;
				state_d         = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.result = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/prsl_dp.sv
// list memories, search registers, counts and result register
module prsl_dp
	import prsl_pkg::*;
#(
	parameter int unsigned LIST_ENTRIES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  prsl_cmd_t cmd,
	output prsl_sts_t sts,
	input  prsl_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output prsl_out_t out_data
);

	localparam int unsigned IW = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(LIST_ENTRIES + 1);

	logic [NumW-1:0] gnum_mem [LIST_ENTRIES];
	logic [ValW-1:0] gval_mem [LIST_ENTRIES];
	logic [NumW-1:0] hnum_mem [LIST_ENTRIES];
	logic [ValW-1:0] hval_mem [LIST_ENTRIES];

	prsl_in_t        item_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   gused_q, hused_q;
	logic            ghit_q, hhit_q, status_q;
	logic [IW-1:0]   gpos_q, hpos_q;
	logic [NumW-1:0] gnum_rd_q, hnum_rd_q;
	logic [ValW-1:0] gval_rd_q, hval_rd_q;
	logic            out_valid_q;
	prsl_out_t       out_q;

	logic [CW-1:0]   glast, hlast;
	logic [IW-1:0]   grd_addr, hrd_addr;
	logic            host_search;
	logic            gfull, hfull, refuse;
	logic            gwr_en, hwr_en;
	logic [IW-1:0]   gwr_addr, hwr_addr;
	logic [NumW-1:0] gwr_num, hwr_num;
	logic [ValW-1:0] gwr_val, hwr_val;

	assign glast       = gused_q - CW'(1);
	assign hlast       = hused_q - CW'(1);
	assign grd_addr    = cmd.last_rd ? glast[IW-1:0] : idx_q[IW-1:0];
	assign hrd_addr    = cmd.last_rd ? hlast[IW-1:0] : idx_q[IW-1:0];
	assign host_search = (item_q.action == ActRemove) || !item_q.guest_only;

	assign gfull  = !ghit_q && (gused_q == CW'(LIST_ENTRIES));
	assign hfull  = !item_q.guest_only && !hhit_q && (hused_q == CW'(LIST_ENTRIES));
	assign refuse = gfull || hfull;

	always_comb begin
		gwr_en   = 1'b0;
		hwr_en   = 1'b0;
		gwr_addr = ghit_q ? gpos_q : gused_q[IW-1:0];
		hwr_addr = hhit_q ? hpos_q : hused_q[IW-1:0];
		gwr_num  = item_q.reg_number;
		hwr_num  = item_q.reg_number;
		gwr_val  = item_q.guest_value;
		hwr_val  = item_q.host_value;
		if (cmd.commit_add && !refuse) begin
			gwr_en = 1'b1;
			hwr_en = !item_q.guest_only;
		end
		if (cmd.commit_move) begin
			gwr_en   = ghit_q;
			hwr_en   = hhit_q;
			gwr_addr = gpos_q;
			hwr_addr = hpos_q;
			gwr_num  = gnum_rd_q;
			hwr_num  = hnum_rd_q;
			gwr_val  = gval_rd_q;
			hwr_val  = hval_rd_q;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (gwr_en) begin
			gnum_mem[gwr_addr] <= gwr_num;
			gval_mem[gwr_addr] <= gwr_val;
		end
		if (hwr_en) begin
			hnum_mem[hwr_addr] <= hwr_num;
			hval_mem[hwr_addr] <= hwr_val;
		end
		if (cmd.search_rd || cmd.last_rd) begin
			gnum_rd_q <= gnum_mem[grd_addr];
			hnum_rd_q <= hnum_mem[hrd_addr];
		end
		if (cmd.last_rd) begin
			gval_rd_q <= gval_mem[grd_addr];
			hval_rd_q <= hval_mem[hrd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.search_cmp) begin
			if (!ghit_q && (idx_q < gused_q) && (gnum_rd_q == item_q.reg_number)) begin
				gpos_q <= idx_q[IW-1:0];
			end
			if (host_search && !hhit_q && (idx_q < hused_q)
					&& (hnum_rd_q == item_q.reg_number)) begin
				hpos_q <= idx_q[IW-1:0];
			end
		end
		if (cmd.result) begin
			out_q.status      <= status_q;
			out_q.guest_hit   <= ghit_q;
			out_q.host_hit    <= hhit_q;
			out_q.guest_count <= CntW'(gused_q);
			out_q.host_count  <= CntW'(hused_q);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			gused_q     <= '0;
			hused_q     <= '0;
			ghit_q      <= 1'b0;
			hhit_q      <= 1'b0;
			status_q    <= StsDone;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q    <= '0;
				ghit_q   <= 1'b0;
				hhit_q   <= 1'b0;
				status_q <= StsDone;
			end
			if (cmd.search_cmp) begin
				idx_q <= idx_q + CW'(1);
				if (!ghit_q && (idx_q < gused_q) && (gnum_rd_q == item_q.reg_number)) begin
					ghit_q <= 1'b1;
				end
				if (host_search && !hhit_q && (idx_q < hused_q)
						&& (hnum_rd_q == item_q.reg_number)) begin
					hhit_q <= 1'b1;
				end
			end
			if (cmd.commit_add) begin
				if (refuse) begin
					status_q <= StsNoRoom;
				end else begin
					if (!ghit_q) begin
						gused_q <= gused_q + CW'(1);
					end
					if (!item_q.guest_only && !hhit_q) begin
						hused_q <= hused_q + CW'(1);
					end
				end
			end
			if (cmd.commit_move) begin
				if (ghit_q) begin
					gused_q <= glast;
				end
				if (hhit_q) begin
					hused_q <= hlast;
				end
			end
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.search_last = (idx_q == CW'(LIST_ENTRIES - 1));
	assign sts.remove      = (item_q.action == ActRemove);
	assign sts.out_busy    = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(gused_q <= CW'(LIST_ENTRIES)) && (hused_q <= CW'(LIST_ENTRIES)))
		else $error("list count above capacity");

	a_refuse_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_add && refuse |=> $stable(gused_q) && $stable(hused_q))
		else $error("refused add changed a count");

	a_move_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_move && ghit_q |-> (CW'(gpos_q) < gused_q))
		else $error("guest hit slot outside used entries");

	a_move_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_move && hhit_q |=> hused_q == $past(hused_q) - CW'(1))
		else $error("host remove did not shrink the list");

endmodule

// File: hw/rtl/paired_register_switch_list.sv
// top level of the paired register switch list
// the search reads every slot of each number memory in turn through a registered read port;
// a remove then reads the last entry of each list and moves it into the hit slot
// a new item is taken only after the last one has written its result into the output register
// reset: both lists empty, no result pending; entry memories are not cleared
module paired_register_switch_list
	import prsl_pkg::*;
#(
	parameter int unsigned LIST_ENTRIES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  prsl_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output prsl_out_t out_data
);

	prsl_cmd_t cmd;
	prsl_sts_t sts;

	prsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	prsl_dp #(
		.LIST_ENTRIES (LIST_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
